### hw/rtl/ctp_pkg.sv
package ctp_pkg;

  localparam int CharW = 8;
  localparam int CountW = 4;
  localparam int RunW = 3;
  localparam int HexW = 24;
  localparam int DecW = 16;
  localparam int HashW = 16;
  localparam int ChanW = 8;

  localparam logic [CharW-1:0] CharPound = 8'h23;
  localparam logic [CountW-1:0] CountMax = 4'd15;
  localparam logic [CountW-1:0] PoundMaxLen = 4'd8;
  localparam logic [RunW-1:0] RunMax = 3'd7;
  localparam logic [RunW-1:0] RunLong = 3'd6;
  localparam logic [RunW-1:0] RunShort = 3'd3;

  typedef enum logic [1:0] {
    ST_HEX  = 2'd0,
    ST_DEC  = 2'd1,
    ST_HASH = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CountW-1:0] char_count;
    logic              starts_with_pound;
    logic [RunW-1:0]   hex_run_len;
    logic              hex_run_open;
    logic [HexW-1:0]   hex_value;
    logic              all_digits;
    logic [DecW-1:0]   decimal_value;
    logic [HashW-1:0]  hash_acc;
  } ctp_state_t;

  typedef struct packed {
    status_t          status;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [HashW-1:0] name_hash;
  } ctp_result_t;

  localparam ctp_state_t StateReset = '{
    char_count:        '0,
    starts_with_pound: 1'b0,
    hex_run_len:       '0,
    hex_run_open:      1'b1,
    hex_value:         '0,
    all_digits:        1'b1,
    decimal_value:     '0,
    hash_acc:          '0
  };

endpackage

### hw/rtl/ctp_if.sv
interface ctp_in_if;
  import ctp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] ch;
  logic             is_end;

  modport source(output valid, ch, is_end, input ready);
  modport sink(input valid, ch, is_end, output ready);
endinterface

interface ctp_out_if;
  import ctp_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [HashW-1:0] name_hash;

  modport source(output valid, status, red, green, blue, name_hash, input ready);
  modport sink(input valid, status, red, green, blue, name_hash, output ready);
endinterface

### hw/rtl/ctp_accum.sv
module ctp_accum
  import ctp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [CharW-1:0] ch,
  input  logic             is_end,
  output ctp_state_t       state
);

  ctp_state_t state_next;
  logic             digit;
  logic             hex_ok;
  logic [3:0]       hex_nib;
  logic [CharW-1:0] lc;

  always_comb begin
    digit = ch inside {[8'h30:8'h39]};
    hex_ok = 1'b1;
    hex_nib = '0;
    if (digit) begin
      hex_nib = ch[3:0];
    end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // letter codes end in 1..6 for a..f
      hex_nib = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    lc = ch;
    if (ch inside {[8'h41:8'h5a]}) begin
      lc = ch + 8'd32;
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      if (is_end) begin
        state_next = StateReset;
      end else begin
        if (!digit) begin
          // h*63 + c as a shift and subtract
          state_next.hash_acc = (state.hash_acc << 6) - state.hash_acc
                                + {{(HashW-CharW){1'b0}}, lc};
          state_next.all_digits = 1'b0;
        end else begin
          state_next.decimal_value = (state.decimal_value << 3)
                                     + (state.decimal_value << 1)
                                     + {{(DecW-4){1'b0}}, ch[3:0]};
        end
        if (state.char_count == '0) begin
          state_next.starts_with_pound = (ch == CharPound);
        end else if (state.hex_run_open) begin
          if (hex_ok) begin
            state_next.hex_value = {state.hex_value[HexW-5:0], hex_nib};
            if (state.hex_run_len < RunMax) begin
              state_next.hex_run_len = state.hex_run_len + 1'b1;
            end
          end else begin
            state_next.hex_run_open = 1'b0;
          end
        end
        if (state.char_count < CountMax) begin
          state_next.char_count = state.char_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/ctp_format.sv
module ctp_format
  import ctp_pkg::*;
(
  input  ctp_state_t  state,
  output ctp_result_t result
);

  logic [4:0]  r5;
  logic [5:0]  g6;
  logic [4:0]  b5;
  logic [13:0] r_wide;
  logic [13:0] g_wide;
  logic [13:0] b_wide;

  assign r5 = state.decimal_value[15:11];
  assign g6 = state.decimal_value[10:5];
  assign b5 = state.decimal_value[4:0];

  // rgb565 channel widening with rounding
  assign r_wide = 14'(r5 * 14'd527) + 14'd23;
  assign g_wide = 14'(g6 * 14'd259) + 14'd33;
  assign b_wide = 14'(b5 * 14'd527) + 14'd23;

  always_comb begin
    result.status = ST_HASH;
    result.red = '0;
    result.green = '0;
    result.blue = '0;
    result.name_hash = state.hash_acc;
    if (state.starts_with_pound) begin
      result.status = ST_BAD;
      if (state.char_count < PoundMaxLen) begin
        if (state.hex_run_len == RunLong) begin
          result.status = ST_HEX;
          result.red = state.hex_value[23:16];
          result.green = state.hex_value[15:8];
          result.blue = state.hex_value[7:0];
        end else if (state.hex_run_len == RunShort) begin
          // nibble times 17 repeats the nibble
          result.status = ST_HEX;
          result.red = {2{state.hex_value[11:8]}};
          result.green = {2{state.hex_value[7:4]}};
          result.blue = {2{state.hex_value[3:0]}};
        end
      end
    end else if (state.all_digits) begin
      result.status = ST_DEC;
      result.red = r_wide[13:6];
      result.green = g_wide[13:6];
      result.blue = b_wide[13:6];
    end
  end

endmodule

### hw/rtl/ctp_out_reg.sv
module ctp_out_reg
  import ctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ctp_result_t result,
  input  logic        out_ready,
  output logic        out_valid,
  output ctp_result_t out_data,
  output logic        can_load
);

  // a new item may enter when the slot is empty or being drained
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

### hw/rtl/color_text_parser.sv
// a result is registered and appears in the cycle after its end item is accepted
// throughput: one item per cycle, characters and end items alike
// an item waits only while an earlier result sits unread in the output register
// reset (synchronous, active high) clears the string state and empties the output
module color_text_parser
  import ctp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ctp_in_if.sink    in_item,
  ctp_out_if.source out_item
);

  ctp_state_t  state;
  ctp_result_t result;
  ctp_result_t out_data;
  logic        accept;
  logic        can_load;

  assign in_item.ready = can_load;
  assign accept = in_item.valid && can_load;

  ctp_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (in_item.ch),
    .is_end (in_item.is_end),
    .state  (state)
  );

  ctp_format u_format (
    .state  (state),
    .result (result)
  );

  ctp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && in_item.is_end),
    .result    (result),
    .out_ready (out_item.ready),
    .out_valid (out_item.valid),
    .out_data  (out_data),
    .can_load  (can_load)
  );

  assign out_item.status = out_data.status;
  assign out_item.red = out_data.red;
  assign out_item.green = out_data.green;
  assign out_item.blue = out_data.blue;
  assign out_item.name_hash = out_data.name_hash;

endmodule

### hw/rtl/ctp_checker.sv
module ctp_checker
  import ctp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_is_end,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input logic [ChanW-1:0] out_red,
  input logic [ChanW-1:0] out_green,
  input logic [ChanW-1:0] out_blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_is_end |=> out_valid)
    else $error("end item gave no result");

  a_char_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_is_end && !out_valid |=> !out_valid)
    else $error("character item gave a result");

  a_no_color_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_HASH || out_status == ST_BAD)
    |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("color channels set without a color");

endmodule

bind color_text_parser ctp_checker u_ctp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .in_is_end  (in_item.is_end),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .out_status (out_item.status),
  .out_red    (out_item.red),
  .out_green  (out_item.green),
  .out_blue   (out_item.blue)
);
